// File: hdl/insertion_shift_counter_assert.svh
// Assertion macros used by the checker file.
`ifndef INSERTION_SHIFT_COUNTER_ASSERT_SVH
`define INSERTION_SHIFT_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/isc_pkg.sv
package isc_pkg;

   localparam int ValueW = 32;
   localparam int TotalW = 31;
   localparam int CountW = 17;

   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic [TotalW-1:0] total_shifts;
      logic [CountW-1:0] element_count;
      logic              overflowed;
   } rsp_type;

   // Control that travels with each item along the row of cells.
   typedef struct packed {
      logic valid;    // an item occupies this slot
      logic has_val;  // the item still carries a value looking for a cell
      logic dropped;  // the item arrived with the store full
      logic last;     // the item ends its sequence
   } token_type;

endpackage

// File: hdl/isc_cell.sv
module isc_cell #(
   parameter int CNT_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  isc_pkg::token_type          in_ctl,
   input  logic [isc_pkg::ValueW-1:0]  in_val,
   input  logic                        in_ins,
   input  logic [CNT_W-1:0]            in_cnt,
   output isc_pkg::token_type          out_ctl,
   output logic [isc_pkg::ValueW-1:0]  out_val,
   output logic                        out_ins,
   output logic [CNT_W-1:0]            out_cnt
);
   import isc_pkg::*;

   logic              occ_ff, occ_in;
   logic [ValueW-1:0] stored_ff, stored_in;
   token_type         ctl_ff, ctl_in;
   logic [ValueW-1:0] val_ff, val_in;
   logic              ins_ff, ins_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              greater;

   assign greater = occ_ff && ($signed(stored_ff) > $signed(in_val));

   always_comb begin
      occ_in    = occ_ff;
      stored_in = stored_ff;
      ctl_in    = in_ctl;
      val_in    = in_val;
      ins_in    = in_ins;
      cnt_in    = in_cnt;
      if (in_ctl.valid && in_ctl.has_val) begin
         if (!occ_ff) begin
            // settle here; the item goes on as a bubble carrying its count
            occ_in         = 1'b1;
            stored_in      = in_val;
            ctl_in.has_val = 1'b0;
         end else begin
            if (in_ins || greater) begin
               cnt_in = in_cnt + CNT_W'(1);
            end
            if (greater) begin
               stored_in = in_val;
               val_in    = stored_ff;
               ins_in    = 1'b1;
            end
         end
      end
      // the closing item empties each cell behind it
      if (in_ctl.valid && in_ctl.last) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         ctl_ff <= '0;
      end else if (advance) begin
         occ_ff <= occ_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stored_ff <= stored_in;
         val_ff    <= val_in;
         ins_ff    <= ins_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_val = val_ff;
   assign out_ins = ins_ff;
   assign out_cnt = cnt_ff;

endmodule

// File: hdl/isc_tail.sv
module isc_tail #(
   parameter int CNT_W = 10,
   parameter int ELEM_W = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  isc_pkg::token_type in_ctl,
   input  logic [CNT_W-1:0]   in_cnt,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output isc_pkg::rsp_type   rsp_data
);
   import isc_pkg::*;

   logic [TotalW-1:0] total_ff, total_in;
   logic [ELEM_W-1:0] elems_ff, elems_in;
   logic              ovf_ff, ovf_in;
   logic              valid_ff, valid_in;
   rsp_type           data_ff, data_in;
   logic [TotalW-1:0] total_sum;
   logic [ELEM_W-1:0] elems_sum;
   logic              ovf_sum;
   logic              take;

   assign take      = advance && in_ctl.valid;
   assign total_sum = total_ff + TotalW'(in_cnt);
   assign elems_sum = elems_ff + ELEM_W'(!in_ctl.dropped);
   assign ovf_sum   = ovf_ff | in_ctl.dropped;

   always_comb begin
      total_in = total_ff;
      elems_in = elems_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (take) begin
         total_in = total_sum;
         elems_in = elems_sum;
         ovf_in   = ovf_sum;
         if (in_ctl.last) begin
            valid_in              = 1'b1;
            data_in.total_shifts  = total_sum;
            data_in.element_count = CountW'(elems_sum);
            data_in.overflowed    = ovf_sum;
            total_in              = '0;
            elems_in              = '0;
            ovf_in                = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         elems_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         elems_ff <= elems_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hdl/insertion_shift_counter.sv
// Inversion counter built on a streaming insertion sort.
// Input channel req_: one signed 32-bit value per item, is_last marks the
// final value of a sequence. Output channel rsp_: one item per sequence,
// carrying the total number of insertion shifts (the inversion count), the
// number of values kept and a flag set when values beyond MAX_N were dropped.
// The values sit in a row of MAX_N compare cells. Each item walks the row one
// cell per cycle while the row is not held, swapping into place and counting
// the larger values it passes, so a new item can enter every cycle unless the
// row is held: throughput is one item per cycle. The result for a closing
// item passes through each cell's register and then the output register.
// The closing item empties each cell as it passes, so the next sequence may
// follow directly behind it.
// Reset clears the cells, the counters and the output valid flag at once.
// A result waiting under rsp_stall holds the row only when the next closing
// item reaches the end; until then items keep being accepted.
module insertion_shift_counter #(
   parameter int MAX_N = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  isc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output isc_pkg::rsp_type rsp_data
);
   import isc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_N);
   localparam int ELEM_W = $clog2(MAX_N + 1);

   token_type         ctl_chain [MAX_N+1];
   logic [ValueW-1:0] val_chain [MAX_N+1];
   logic              ins_chain [MAX_N+1];
   logic [CNT_W-1:0]  cnt_chain [MAX_N+1];

   logic              advance;
   logic              accept;
   logic              full;
   logic [ELEM_W-1:0] fill_ff, fill_in;

   // hold everything only when a closing item cannot leave
   assign advance   = !(ctl_chain[MAX_N].valid && ctl_chain[MAX_N].last
                        && rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign full      = (fill_ff == ELEM_W'(MAX_N));

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_data.is_last) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + ELEM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign ctl_chain[0].valid   = accept;
   assign ctl_chain[0].has_val = !full;
   assign ctl_chain[0].dropped = full;
   assign ctl_chain[0].last    = req_data.is_last;
   assign val_chain[0]         = req_data.value;
   assign ins_chain[0]         = 1'b0;
   assign cnt_chain[0]         = '0;

   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      isc_cell #(.CNT_W(CNT_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .in_ctl  (ctl_chain[i]),
         .in_val  (val_chain[i]),
         .in_ins  (ins_chain[i]),
         .in_cnt  (cnt_chain[i]),
         .out_ctl (ctl_chain[i+1]),
         .out_val (val_chain[i+1]),
         .out_ins (ins_chain[i+1]),
         .out_cnt (cnt_chain[i+1])
      );
   end

   isc_tail #(.CNT_W(CNT_W), .ELEM_W(ELEM_W)) u_tail (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (ctl_chain[MAX_N]),
      .in_cnt    (cnt_chain[MAX_N]),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/isc_checker.sv
module isc_checker #(
   parameter int MAX_N = 1024
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input isc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input isc_pkg::rsp_type rsp_data
);
   import isc_pkg::*;
`include "insertion_shift_counter_assert.svh"

   `ISC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "result item changed while stalled")

   `ISC_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_data), "input item changed while stalled")

   `ISC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall,
      "input stalled with no result held")

   `ISC_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid,
      rsp_data.element_count <= CountW'(MAX_N)
         && (!rsp_data.overflowed || rsp_data.element_count == CountW'(MAX_N)),
      "element count or overflow flag out of range")

   `ISC_ASSERT_NOW(a_short_total, clock, reset, rsp_valid && rsp_data.element_count < CountW'(2),
      rsp_data.total_shifts == '0, "shifts reported for fewer than two elements")

endmodule

bind insertion_shift_counter isc_checker #(.MAX_N(MAX_N)) u_isc_checker (.*);
